// File: rtl/sorted_set_table_defines.svh
// assertion macros for the sorted set table
`ifndef SORTED_SET_TABLE_DEFINES_SVH
`define SORTED_SET_TABLE_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define SST_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted set table check failed");

// next-cycle implication
`define SST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted set table check failed");

`endif

// File: rtl/sst_pkg.sv
`default_nettype none
package sst_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   // action codes
   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] element_value;
   } req_type;

   typedef struct packed {
      logic       was_present;
      logic       changed;
      logic       full_reject;
      logic [6:0] element_count;
   } rsp_type;

   // commands broadcast to every cell
   typedef struct packed {
      logic compare;
      logic insert;
      logic remove;
   } cell_ctrl_type;

   // flags each cell keeps from the compare cycle
   typedef struct packed {
      logic ge;
      logic after;
      logic eq;
   } cell_flag_type;

endpackage
`default_nettype wire

// File: rtl/sorted_set_table.sv
`default_nettype none
// sorted set table: keeps up to CAPACITY distinct signed 32-bit values in
// ascending order in a row of compare-and-shift cells. An item is taken when
// start is high and busy is low; its answer appears on rsp_item for exactly one
// cycle with rsp_valid high, once the compare and update states have passed,
// and is taken in that cycle because the receiver cannot hold it off. The next
// item may be started in the very cycle the answer is shown, so the block works
// on one item at a time: first all cells compare against the key in parallel,
// then come the decision and the one-place shift along the row, and then the
// registered answer is shown and the port is free again.
// No clearing pass is needed after reset.
module sorted_set_table #(
   parameter int CAPACITY = sst_pkg::CAPACITY_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire sst_pkg::req_type req_item,
   output      logic             busy,
   output      logic             rsp_valid,
   output      sst_pkg::rsp_type rsp_item
);
   import sst_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   state_type         state_ff, state_in;
   req_type           req_ff;
   logic [CW-1:0]     count_ff, count_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cell_ctrl_type     ctrl;

   logic signed [31:0] entry_w [CAPACITY];
   cell_flag_type      flag_w  [CAPACITY];
   logic [CAPACITY-1:0] eq_vec;

   logic              hit, full, do_insert, do_remove, reject;
   logic [CW+6:0]     count_ext;

   // row of cells, each handing its entry to both neighbours
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic               after_left;
      logic signed [31:0] left_entry, right_entry;
      if (i == 0) begin : g_first
         assign after_left = 1'b0;
         assign left_entry = '0;
      end else begin : g_mid
         assign after_left = flag_w[i-1].after;
         assign left_entry = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = entry_w[i+1];
      end
      sst_cell #(
         .INDEX       (i),
         .COUNT_WIDTH (CW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .key_value   (req_ff.element_value),
         .count       (count_ff),
         .after_left  (after_left),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry_w[i]),
         .flags       (flag_w[i])
      );
      assign eq_vec[i] = flag_w[i].eq;
   end

   // decision from the flags registered in the compare cycle
   assign hit       = |eq_vec;
   assign full      = count_ff == CW'(CAPACITY);
   assign do_insert = (req_ff.action == ACT_ADD) && !hit && !full;
   assign reject    = (req_ff.action == ACT_ADD) && !hit && full;
   assign do_remove = (req_ff.action == ACT_REMOVE) && hit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (start) state_in = ST_COMPARE;
         ST_COMPARE: state_in = ST_UPDATE;
         ST_UPDATE:  state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // count after the item, moved only in the update cycle
   always_comb begin
      count_in = count_ff;
      if (state_ff == ST_UPDATE) begin
         if (do_insert) begin
            count_in = count_ff + CW'(1);
         end else if (do_remove) begin
            count_in = count_ff - CW'(1);
         end
      end
   end

   // low seven bits reported
   assign count_ext = {7'd0, count_in};

   // outputs of the sequencer
   always_comb begin
      ctrl         = '0;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_COMPARE: begin
            ctrl.compare = 1'b1;
         end
         ST_UPDATE: begin
            ctrl.insert  = do_insert;
            ctrl.remove  = do_remove;
            rsp_in.was_present   = hit;
            rsp_in.changed       = do_insert || do_remove;
            rsp_in.full_reject   = reject;
            rsp_in.element_count = count_ext[6:0];
            rsp_valid_in         = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (state_ff == ST_IDLE && start) begin
         req_ff <= req_item;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/sst_cell.sv
`default_nettype none
module sst_cell #(
   parameter int INDEX       = 0,
   parameter int COUNT_WIDTH = 7
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sst_pkg::cell_ctrl_type     ctrl,
   input  wire logic signed [31:0]         key_value,
   input  wire logic [COUNT_WIDTH-1:0]     count,
   input  wire logic                       after_left,
   input  wire logic signed [31:0]         left_entry,
   input  wire logic signed [31:0]         right_entry,
   output      logic signed [31:0]         entry,
   output      sst_pkg::cell_flag_type     flags
);
   import sst_pkg::*;

   logic signed [31:0] entry_ff, entry_in;
   cell_flag_type      flag_ff, flag_in;
   logic               occupied;

   assign occupied = count > COUNT_WIDTH'(INDEX);

   always_comb begin
      flag_in = flag_ff;
      if (ctrl.compare) begin
         flag_in.ge    = occupied && (entry_ff >= key_value);
         flag_in.eq    = occupied && (entry_ff == key_value);
         flag_in.after = !occupied || flag_in.ge;
      end
   end

   // insert opens a gap at the first cell at or after the key, remove closes it
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert && flag_ff.after) begin
         entry_in = after_left ? left_entry : key_value;
      end else if (ctrl.remove && flag_ff.ge) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         flag_ff <= '0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   assign entry = entry_ff;
   assign flags = flag_ff;

endmodule
`default_nettype wire

// File: rtl/sst_checker.sv
`default_nettype none
`include "sorted_set_table_defines.svh"
module sst_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire sst_pkg::rsp_type rsp_item
);
   import sst_pkg::*;

   // an accepted item locks the command port
   `SST_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // every accepted item is answered once the compare and update states have passed
   `SST_ASSERT_NOW(a_accept_answer, start && !busy, ##3 rsp_valid)
   // the answer shows once the port is free again
   `SST_ASSERT_NOW(a_answer_idle, rsp_valid, !busy)
   // a refused add never changes the set
   `SST_ASSERT_NOW(a_reject_nochange, rsp_valid && rsp_item.full_reject,
      !rsp_item.changed && !rsp_item.was_present)

endmodule

bind sorted_set_table sst_checker u_sst_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire

// File: dv/sorted_set_table_test.sv
`timescale 1ns / 1ps
module sorted_set_table_test;
   import sst_pkg::*;

   // the block is built with its default capacity
   localparam int TABLE_DEPTH = CAPACITY_DEFAULT;
   // action code that the block treats like a query
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1530;
   // random part runs in phases that alternate between filling and draining
   localparam int PHASE_ITEMS = 150;
   localparam int POOL_SIZE = 90;
   localparam int MISMATCH_REPORTS = 10;
   // no random gaps from the sender while the accepted count sits in this window
   localparam int QUIET_FIRST = 700;
   localparam int QUIET_LAST = 1000;
   localparam int IDLE_PERCENT = 15;
   localparam int TAIL_CYCLES = 8;

   localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POSITIVE = 32'sh7fff_ffff;

   typedef struct {
      req_type item;
      bit      drain_first;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   // items waiting for the driver, answers waiting for the block
   pending_type        pending_items[$];
   rsp_type            expected_answers[$];
   // our own copy of the set, kept in ascending signed order
   logic signed [31:0] set_members[$];
   logic signed [31:0] value_pool[$];
   int unsigned        accepted_count = 0;
   int unsigned        fail_count = 0;

   sorted_set_table i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // applies one item to the set copy and returns the answer the block should give
   function automatic rsp_type apply_to_set(req_type r);
      rsp_type            answer;
      logic signed [31:0] key;
      int                 slot;
      bit                 hit;
      answer = '0;
      key = r.element_value;
      slot = set_members.size();
      hit = 1'b0;
      // first entry not below the key, in signed order
      for (int i = 0; i < set_members.size(); i++) begin
         if (slot == set_members.size() && set_members[i] >= key) begin
            slot = i;
            hit = (set_members[i] == key);
         end
      end
      case (r.action)
         ACT_ADD: begin
            // a duplicate add is silently ignored, even when full
            if (!hit) begin
               if (set_members.size() >= TABLE_DEPTH) begin
                  answer.full_reject = 1'b1;
               end else begin
                  set_members.insert(slot, key);
                  answer.changed = 1'b1;
               end
            end
         end
         ACT_REMOVE: begin
            if (hit) begin
               set_members.delete(slot);
               answer.changed = 1'b1;
            end
         end
         default: begin
            // query and the unused code only report membership
         end
      endcase
      answer.was_present = hit;
      answer.element_count = 7'(set_members.size());
      return answer;
   endfunction

   task automatic queue_item(logic [1:0] act, logic signed [31:0] val, bit drain);
      pending_type p;
      p.item.action = act;
      p.item.element_value = val;
      p.drain_first = drain;
      pending_items.push_back(p);
   endtask

   task automatic note_failure(string why, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= MISMATCH_REPORTS)
         $display("%0t: %s: expected present=%0b changed=%0b reject=%0b count=%0d, got present=%0b changed=%0b reject=%0b count=%0d",
                  $realtime, why, want.was_present, want.changed, want.full_reject,
                  want.element_count, got.was_present, got.changed, got.full_reject,
                  got.element_count);
   endtask

   // driver: an item is taken at an edge where start is high and busy is low;
   // start and the item are held until then, and a fresh decision is made only
   // once the previous item has gone
   always @(posedge clock) begin
      bit taken;
      bit launch;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            expected_answers.push_back(apply_to_set(req_item));
            accepted_count++;
         end
         if (!start || taken) begin
            launch = 1'b0;
            if (pending_items.size() > 0) begin
               launch = 1'b1;
               // hold-off: let every outstanding answer come back first
               if (pending_items[0].drain_first && expected_answers.size() > 0)
                  launch = 1'b0;
               // random gaps, except for one long stretch
               if ((accepted_count < QUIET_FIRST || accepted_count >= QUIET_LAST) &&
                   $urandom_range(99) < IDLE_PERCENT)
                  launch = 1'b0;
            end
            if (launch) begin
               req_item <= pending_items[0].item;
               pending_items.pop_front();
            end
            // single assignment to start per edge, so a held-high start never glitches
            start <= launch;
         end
      end
   end

   // monitor: each answer is shown for one cycle only and is taken at that edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            note_failure("answer with no item outstanding", '0, rsp_item);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_item.was_present !== want.was_present ||
                rsp_item.changed !== want.changed ||
                rsp_item.full_reject !== want.full_reject ||
                rsp_item.element_count !== want.element_count)
               note_failure("answer mismatch", want, rsp_item);
         end
      end
   end

   initial begin
      int                 roll;
      logic [1:0]         act;
      logic signed [31:0] val;
      bit                 fill_mode;

      // directed part: empty set, the extremes, duplicates, absent values and
      // the unused action code
      queue_item(ACT_QUERY, MOST_NEGATIVE, 1'b0);
      queue_item(ACT_REMOVE, 32'sd0, 1'b0);
      queue_item(ACT_ADD, MOST_NEGATIVE, 1'b0);
      queue_item(ACT_ADD, MOST_POSITIVE, 1'b0);
      queue_item(ACT_ADD, 32'sd0, 1'b0);
      queue_item(ACT_ADD, -32'sd1, 1'b0);
      queue_item(ACT_ADD, 32'sd1, 1'b0);
      queue_item(ACT_ADD, 32'sd0, 1'b0);
      queue_item(ACT_ADD, MOST_POSITIVE, 1'b0);
      queue_item(ACT_QUERY, MOST_POSITIVE, 1'b0);
      queue_item(ACT_QUERY, 32'sd5, 1'b0);
      queue_item(ACT_UNUSED, MOST_NEGATIVE, 1'b0);
      queue_item(ACT_UNUSED, 32'sd7, 1'b0);
      queue_item(ACT_REMOVE, 32'sd5, 1'b0);
      queue_item(ACT_REMOVE, MOST_NEGATIVE, 1'b0);
      queue_item(ACT_REMOVE, MOST_POSITIVE, 1'b0);
      queue_item(ACT_REMOVE, 32'sd0, 1'b0);
      queue_item(ACT_QUERY, 32'sd0, 1'b0);
      queue_item(ACT_ADD, 32'sh5555_5555, 1'b0);
      queue_item(ACT_ADD, 32'shaaaa_aaaa, 1'b0);
      queue_item(ACT_QUERY, 32'shaaaa_aaaa, 1'b0);
      queue_item(ACT_ADD, MOST_NEGATIVE, 1'b0);

      // random part: a pool of values a little larger than the table, so that
      // fill phases reach the full table and drain phases empty it again
      fill_mode = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            fill_mode = !fill_mode;
            if (fill_mode) begin
               value_pool.delete();
               for (int k = 0; k < POOL_SIZE; k++) begin
                  roll = $urandom_range(9);
                  if (roll == 0)
                     value_pool.push_back($urandom_range(1) ? MOST_POSITIVE : MOST_NEGATIVE);
                  else if (roll < 4)
                     value_pool.push_back($signed($urandom_range(40)) - 32'sd20);
                  else
                     value_pool.push_back($urandom);
               end
            end
         end
         roll = $urandom_range(99);
         if (fill_mode)
            act = (roll < 60) ? ACT_ADD : (roll < 75) ? ACT_REMOVE :
                  (roll < 95) ? ACT_QUERY : ACT_UNUSED;
         else
            act = (roll < 20) ? ACT_ADD : (roll < 75) ? ACT_REMOVE :
                  (roll < 95) ? ACT_QUERY : ACT_UNUSED;
         // mostly pool values for hits, some fresh noise
         if ($urandom_range(9) == 0)
            val = $urandom;
         else
            val = value_pool[$urandom_range(POOL_SIZE - 1)];
         // sender waits for an empty pipeline at the start and in the middle
         queue_item(act, val, n == 0 || n == RANDOM_ITEMS / 2);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() > 0 || start) @(posedge clock);
      while (expected_answers.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_answers.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/sst_pkg.sv
rtl/sst_cell.sv
rtl/sorted_set_table.sv
rtl/sst_checker.sv
dv/sorted_set_table_test.sv
